>>> design/tts_pkg.sv
package tts_pkg;

	// Sizes of the grid and of the scrollback ring
	localparam int COLS_MAX      = 64;
	localparam int ROWS_MAX      = 32;
	localparam int HISTORY_DEPTH = 64;

	localparam int RING_LINES = HISTORY_DEPTH + ROWS_MAX;
	localparam int MEM_DEPTH  = RING_LINES * COLS_MAX;
	localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int SLOT_W     = (RING_LINES > 1) ? $clog2(RING_LINES) : 1;
	localparam int SUM_W      = $clog2(2 * RING_LINES) + 1;
	localparam int COL_W      = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
	localparam int CCNT_W     = $clog2(COLS_MAX + 1);
	localparam int ROW_W      = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
	localparam int RCNT_W     = $clog2(ROWS_MAX + 1);
	localparam int HIST_W     = $clog2(HISTORY_DEPTH + 1);

	// Field widths at the ports
	localparam int REQ_W      = 3;
	localparam int CODE_W     = 8;
	localparam int VROW_W     = 5;
	localparam int VCOL_W     = 6;
	localparam int CHAR_W     = 7;
	localparam int CROW_W     = 5;
	localparam int CCOL_W     = 7;
	localparam int HLINES_W   = 7;
	localparam int VOFF_W     = 7;
	localparam int CFG_COLS_W = 7;
	localparam int CFG_ROWS_W = 6;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = 1;
	localparam int CMDQ_CNT_W = 2;

	// Character codes
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 7'h20;
	localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [CODE_W-1:0] PRINT_LO     = 8'h20;
	localparam logic [CODE_W-1:0] PRINT_HI     = 8'h7F;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_CHAR  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd1;
	localparam logic [REQ_W-1:0] REQ_UP    = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DOWN  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

	// Register indexes and reset values
	localparam logic CFG_IDX_COLS = 1'b0;
	localparam logic CFG_IDX_ROWS = 1'b1;
	localparam logic [CFG_COLS_W-1:0] CFG_COLS_RST = 7'd40;
	localparam logic [CFG_ROWS_W-1:0] CFG_ROWS_RST = 6'd16;

	typedef enum logic [2:0] {
		OP_NOP     = 3'd0,
		OP_PUT     = 3'd1,
		OP_NEWLINE = 3'd2,
		OP_CLEAR   = 3'd3,
		OP_UP      = 3'd4,
		OP_DOWN    = 3'd5,
		OP_READ    = 3'd6
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] code;
		logic [VROW_W-1:0] vrow;
		logic [VCOL_W-1:0] vcol;
	} cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0]   cell_char;
		logic [CROW_W-1:0]   cursor_row;
		logic [CCOL_W-1:0]   cursor_col;
		logic [HLINES_W-1:0] history_lines;
		logic [VOFF_W-1:0]   view_offset;
	} result_t;

	// Reduce a sum below twice the ring size into a ring slot
	function automatic logic [SLOT_W-1:0] ring_wrap(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] r;
		if (v >= SUM_W'(RING_LINES)) begin
			r = v - SUM_W'(RING_LINES);
		end else begin
			r = v;
		end
		return SLOT_W'(r);
	endfunction

	// Memory address of one cell
	function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
		input logic [COL_W-1:0] col);
		return ADDR_W'(slot) * ADDR_W'(COLS_MAX) + ADDR_W'(col);
	endfunction

	function automatic logic [CCNT_W-1:0] sat_cols(input logic [CFG_COLS_W-1:0] v);
		logic [CCNT_W-1:0] r;
		if (v == '0) begin
			r = CCNT_W'(1);
		end else if (32'(v) > COLS_MAX) begin
			r = CCNT_W'(COLS_MAX);
		end else begin
			r = CCNT_W'(v);
		end
		return r;
	endfunction

	function automatic logic [RCNT_W-1:0] sat_rows(input logic [CFG_ROWS_W-1:0] v);
		logic [RCNT_W-1:0] r;
		if (v == '0) begin
			r = RCNT_W'(1);
		end else if (32'(v) > ROWS_MAX) begin
			r = RCNT_W'(ROWS_MAX);
		end else begin
			r = RCNT_W'(v);
		end
		return r;
	endfunction

endpackage

>>> design/tts_ram.sv
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/tts_front.sv
module tts_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [tts_pkg::REQ_W-1:0]    req_type,
	input  logic [tts_pkg::CODE_W-1:0]   char_code,
	input  logic [tts_pkg::VROW_W-1:0]   view_row,
	input  logic [tts_pkg::VCOL_W-1:0]   view_col,
	output logic                         cmd_valid,
	output tts_pkg::cmd_t                cmd,
	input  logic                         cmd_pop
);

	tts_pkg::cmd_t                       cmd_in;
	tts_pkg::cmd_t                       entry_q [tts_pkg::CMDQ_DEPTH];
	logic [tts_pkg::CMDQ_PTR_W-1:0]      wr_ptr_q;
	logic [tts_pkg::CMDQ_PTR_W-1:0]      rd_ptr_q;
	logic [tts_pkg::CMDQ_CNT_W-1:0]      count_q;
	logic                                push_ok;

	// Classify the incoming request
	always_comb begin
		cmd_in.code = char_code[tts_pkg::CHAR_W-1:0];
		cmd_in.vrow = view_row;
		cmd_in.vcol = view_col;
		case (req_type)
			tts_pkg::REQ_CHAR: begin
				if (char_code == tts_pkg::NEWLINE_CODE) begin
					cmd_in.op = tts_pkg::OP_NEWLINE;
				end else if (char_code >= tts_pkg::PRINT_LO && char_code <= tts_pkg::PRINT_HI) begin
					cmd_in.op = tts_pkg::OP_PUT;
				end else begin
					cmd_in.op = tts_pkg::OP_NOP;
				end
			end
			tts_pkg::REQ_CLEAR: cmd_in.op = tts_pkg::OP_CLEAR;
			tts_pkg::REQ_UP:    cmd_in.op = tts_pkg::OP_UP;
			tts_pkg::REQ_DOWN:  cmd_in.op = tts_pkg::OP_DOWN;
			tts_pkg::REQ_READ:  cmd_in.op = tts_pkg::OP_READ;
			default:            cmd_in.op = tts_pkg::OP_NOP;
		endcase
	end

	assign full      = (count_q == tts_pkg::CMDQ_CNT_W'(tts_pkg::CMDQ_DEPTH));
	assign push_ok   = push && !full;
	assign cmd_valid = (count_q != '0);
	assign cmd       = entry_q[rd_ptr_q];

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + tts_pkg::CMDQ_PTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + tts_pkg::CMDQ_PTR_W'(1);
			end
			if (push_ok && !cmd_pop) begin
				count_q <= count_q + tts_pkg::CMDQ_CNT_W'(1);
			end else if (!push_ok && cmd_pop) begin
				count_q <= count_q - tts_pkg::CMDQ_CNT_W'(1);
			end
		end
	end

endmodule

>>> design/tts_back.sv
module tts_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  tts_pkg::cmd_t                   cmd,
	output logic                            cmd_pop,
	input  logic [tts_pkg::CFG_COLS_W-1:0]  cfg_cols,
	input  logic [tts_pkg::CFG_ROWS_W-1:0]  cfg_rows,
	input  logic                            pop,
	output logic                            empty,
	output tts_pkg::result_t                result
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_SCROLL = 11'b000_0000_0010,
		S_BLANK  = 11'b000_0000_0100,
		S_SLOT   = 11'b000_0000_1000,
		S_FILL   = 11'b000_0001_0000,
		S_WRITE  = 11'b000_0010_0000,
		S_RBASE  = 11'b000_0100_0000,
		S_RSLOT  = 11'b000_1000_0000,
		S_RREAD  = 11'b001_0000_0000,
		S_RDATA  = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	state_t                               state_q;
	tts_pkg::cmd_t                        cmd_q;
	logic [tts_pkg::SLOT_W-1:0]           ring_head_q;
	logic [tts_pkg::ROW_W-1:0]            cur_row_q;
	logic [tts_pkg::CCNT_W-1:0]           cur_col_q;
	logic [tts_pkg::HIST_W-1:0]           hist_q;
	logic [tts_pkg::HIST_W-1:0]           sb_q;
	logic [tts_pkg::CCNT_W-1:0]           act_cols_q;
	logic [tts_pkg::RCNT_W-1:0]           act_rows_q;
	logic [tts_pkg::RING_LINES-1:0]       row_valid_q;
	logic [tts_pkg::COL_W-1:0]            sweep_q;
	logic [tts_pkg::SLOT_W-1:0]           base_q;
	logic [tts_pkg::SLOT_W-1:0]           slot_q;
	logic [tts_pkg::CHAR_W-1:0]           cell_q;
	logic                                 inb_q;
	logic                                 out_valid_q;
	tts_pkg::result_t                     result_q;

	logic                                 row_last;
	logic [tts_pkg::HIST_W-1:0]           hist_inc;
	logic [tts_pkg::HIST_W:0]             sb_inc;
	logic [tts_pkg::SLOT_W-1:0]           blank_slot;
	logic                                 mem_we;
	logic [tts_pkg::ADDR_W-1:0]           mem_waddr;
	logic [tts_pkg::CHAR_W-1:0]           mem_wdata;
	logic [tts_pkg::ADDR_W-1:0]           mem_raddr;
	logic [tts_pkg::CHAR_W-1:0]           mem_rdata;

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid && !out_valid_q;
	assign empty   = !out_valid_q;
	assign result  = result_q;

	// Cursor on the last row, scroll arithmetic
	assign row_last = (tts_pkg::RCNT_W'(cur_row_q) + tts_pkg::RCNT_W'(1)) >= act_rows_q;
	assign hist_inc = (hist_q < tts_pkg::HIST_W'(tts_pkg::HISTORY_DEPTH)) ?
		hist_q + tts_pkg::HIST_W'(1) : hist_q;
	assign sb_inc   = {1'b0, sb_q} + (tts_pkg::HIST_W + 1)'(1);
	assign blank_slot = tts_pkg::ring_wrap(tts_pkg::SUM_W'(ring_head_q) +
		tts_pkg::SUM_W'(act_rows_q) - tts_pkg::SUM_W'(1));

	// Memory port steering: row fill, character write, cell read
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tts_pkg::mem_addr(slot_q, sweep_q);
		mem_wdata = tts_pkg::SPACE_CODE;
		if (state_q == S_FILL) begin
			mem_we = !row_valid_q[slot_q];
		end else if (state_q == S_WRITE) begin
			mem_we    = 1'b1;
			mem_waddr = tts_pkg::mem_addr(slot_q, cur_col_q[tts_pkg::COL_W-1:0]);
			mem_wdata = cmd_q.code;
		end
	end
	assign mem_raddr = tts_pkg::mem_addr(slot_q, tts_pkg::COL_W'(cmd_q.vcol));

	tts_ram #(
		.WIDTH (tts_pkg::CHAR_W),
		.DEPTH (tts_pkg::MEM_DEPTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			ring_head_q <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			hist_q      <= '0;
			sb_q        <= '0;
			act_cols_q  <= tts_pkg::sat_cols(tts_pkg::CFG_COLS_RST);
			act_rows_q  <= tts_pkg::sat_rows(tts_pkg::CFG_ROWS_RST);
			row_valid_q <= '0;
			sweep_q     <= '0;
			base_q      <= '0;
			slot_q      <= '0;
			cell_q      <= tts_pkg::SPACE_CODE;
			inb_q       <= 1'b0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else begin
			// Drop the result once taken
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && !out_valid_q) begin
						cmd_q   <= cmd;
						cell_q  <= tts_pkg::SPACE_CODE;
						sweep_q <= '0;
						state_q <= S_DONE;
						case (cmd.op)
							tts_pkg::OP_CLEAR: begin
								act_cols_q  <= tts_pkg::sat_cols(cfg_cols);
								act_rows_q  <= tts_pkg::sat_rows(cfg_rows);
								row_valid_q <= '0;
								ring_head_q <= '0;
								cur_row_q   <= '0;
								cur_col_q   <= '0;
								hist_q      <= '0;
								sb_q        <= '0;
							end
							tts_pkg::OP_UP: begin
								if (sb_q < hist_q) begin
									sb_q <= sb_q + tts_pkg::HIST_W'(1);
								end
							end
							tts_pkg::OP_DOWN: begin
								if (sb_q != '0) begin
									sb_q <= sb_q - tts_pkg::HIST_W'(1);
								end
							end
							tts_pkg::OP_NEWLINE: begin
								cur_col_q <= '0;
								if (row_last) begin
									state_q <= S_SCROLL;
								end else begin
									cur_row_q <= cur_row_q + tts_pkg::ROW_W'(1);
								end
							end
							tts_pkg::OP_PUT: begin
								state_q <= S_SLOT;
								// Pending wrap: take the newline first
								if (cur_col_q >= act_cols_q) begin
									cur_col_q <= '0;
									if (row_last) begin
										state_q <= S_SCROLL;
									end else begin
										cur_row_q <= cur_row_q + tts_pkg::ROW_W'(1);
									end
								end
							end
							tts_pkg::OP_READ: state_q <= S_RBASE;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_SCROLL: begin
					ring_head_q <= tts_pkg::ring_wrap(tts_pkg::SUM_W'(ring_head_q) +
						tts_pkg::SUM_W'(1));
					hist_q <= hist_inc;
					if (sb_q != '0) begin
						sb_q <= (sb_inc > {1'b0, hist_inc}) ? hist_inc :
							sb_inc[tts_pkg::HIST_W-1:0];
					end
					state_q <= S_BLANK;
				end
				S_BLANK: begin
					// Fresh bottom line reads as spaces until filled
					row_valid_q[blank_slot] <= 1'b0;
					state_q <= (cmd_q.op == tts_pkg::OP_PUT) ? S_SLOT : S_DONE;
				end
				S_SLOT: begin
					slot_q  <= tts_pkg::ring_wrap(tts_pkg::SUM_W'(ring_head_q) +
						tts_pkg::SUM_W'(cur_row_q));
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (row_valid_q[slot_q]) begin
						state_q <= S_WRITE;
					end else begin
						sweep_q <= sweep_q + tts_pkg::COL_W'(1);
						if (sweep_q == tts_pkg::COL_W'(tts_pkg::COLS_MAX - 1)) begin
							row_valid_q[slot_q] <= 1'b1;
							state_q <= S_WRITE;
						end
					end
				end
				S_WRITE: begin
					cur_col_q <= cur_col_q + tts_pkg::CCNT_W'(1);
					state_q   <= S_DONE;
				end
				S_RBASE: begin
					// Slot of the top visible line
					base_q  <= tts_pkg::ring_wrap(tts_pkg::SUM_W'(ring_head_q) +
						tts_pkg::SUM_W'(tts_pkg::RING_LINES) - tts_pkg::SUM_W'(sb_q));
					state_q <= S_RSLOT;
				end
				S_RSLOT: begin
					slot_q  <= tts_pkg::ring_wrap(tts_pkg::SUM_W'(base_q) +
						tts_pkg::SUM_W'(cmd_q.vrow));
					state_q <= S_RREAD;
				end
				S_RREAD: begin
					inb_q <= (32'(cmd_q.vrow) < 32'(act_rows_q)) &&
						(32'(cmd_q.vcol) < 32'(act_cols_q)) && row_valid_q[slot_q];
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					cell_q  <= inb_q ? mem_rdata : tts_pkg::SPACE_CODE;
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_valid_q            <= 1'b1;
					result_q.cell_char     <= cell_q;
					result_q.cursor_row    <= tts_pkg::CROW_W'(cur_row_q);
					result_q.cursor_col    <= tts_pkg::CCOL_W'(cur_col_q);
					result_q.history_lines <= tts_pkg::HLINES_W'(hist_q);
					result_q.view_offset   <= tts_pkg::VOFF_W'(sb_q);
					state_q                <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_view_in_history: assert property (@(posedge clk) disable iff (!arst_n)
		sb_q <= hist_q)
		else $error("view offset past history count");

	a_cursor_row_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_row_q) < 32'(act_rows_q))
		else $error("cursor row outside grid");

	a_cursor_col_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cur_col_q <= act_cols_q)
		else $error("cursor column past pending wrap");

	a_write_advances: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |=> cur_col_q == $past(cur_col_q) + tts_pkg::CCNT_W'(1))
		else $error("character write did not advance cursor");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> !out_valid_q)
		else $error("result overwritten before taken");
`endif

endmodule

>>> design/text_terminal_scrollback.sv
// Character terminal with scrollback. Requests enter a two-entry queue through push/full
// and each one yields exactly one result, in order, on empty/pop. The sequencer takes one
// request at a time once the result register is free. A printable byte that finds a pending
// wrap first takes the newline, with a scroll on the last row, and one that lands on a line
// that has not been written since it was blanked first fills that line with spaces one cell
// per cycle through the single write port of the line memory. A taken result frees the
// sequencer for the next request. Per-line valid bits make the whole screen read as spaces
// right after reset or a clear, so no clearing pass is needed. grid_cols (offset 0) and
// grid_rows (offset 4) are latched, saturated to 1..64 and 1..32, only at reset or at a
// clear request.
module text_terminal_scrollback (
	input  logic                                clk,
	input  logic                                arst_n,
	// request queue
	input  logic                                push,
	output logic                                full,
	input  logic [tts_pkg::REQ_W-1:0]           req_type,
	input  logic [tts_pkg::CODE_W-1:0]          char_code,
	input  logic [tts_pkg::VROW_W-1:0]          view_row,
	input  logic [tts_pkg::VCOL_W-1:0]          view_col,
	// result queue
	output logic                                empty,
	input  logic                                pop,
	output logic [tts_pkg::CHAR_W-1:0]          cell_char,
	output logic [tts_pkg::CROW_W-1:0]          cursor_row,
	output logic [tts_pkg::CCOL_W-1:0]          cursor_col,
	output logic [tts_pkg::HLINES_W-1:0]        history_lines,
	output logic [tts_pkg::VOFF_W-1:0]          view_offset,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tts_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [tts_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [tts_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	logic [tts_pkg::CFG_COLS_W-1:0] grid_cols_q;
	logic [tts_pkg::CFG_ROWS_W-1:0] grid_rows_q;
	logic                           cfg_wr;
	logic                           cmd_valid;
	logic                           cmd_pop;
	tts_pkg::cmd_t                  cmd;
	tts_pkg::result_t               res;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= tts_pkg::CFG_COLS_RST;
			grid_rows_q <= tts_pkg::CFG_ROWS_RST;
		end else if (cfg_wr) begin
			if (paddr[tts_pkg::APB_ADDR_W-1] == tts_pkg::CFG_IDX_COLS) begin
				grid_cols_q <= pwdata[tts_pkg::CFG_COLS_W-1:0];
			end else begin
				grid_rows_q <= pwdata[tts_pkg::CFG_ROWS_W-1:0];
			end
		end
	end

	assign prdata = (paddr[tts_pkg::APB_ADDR_W-1] == tts_pkg::CFG_IDX_ROWS) ?
		tts_pkg::APB_DATA_W'(grid_rows_q) : tts_pkg::APB_DATA_W'(grid_cols_q);

	tts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.char_code (char_code),
		.view_row  (view_row),
		.view_col  (view_col),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	tts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_cols  (grid_cols_q),
		.cfg_rows  (grid_rows_q),
		.pop       (pop),
		.empty     (empty),
		.result    (res)
	);

	assign cell_char     = res.cell_char;
	assign cursor_row    = res.cursor_row;
	assign cursor_col    = res.cursor_col;
	assign history_lines = res.history_lines;
	assign view_offset   = res.view_offset;

endmodule
